/* rtl/lpd_pkg.sv */
// Shared types, constants and coefficient tables for the Legendre
// polynomial and derivative unit. No dependencies.
package lpd_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COEF_FRAC = 16;
    localparam int ORDER_CAP = 31;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF_X    = 1 << (FRAC_BITS - 1);
    localparam int HALF_C    = 1 << (COEF_FRAC - 1);

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic        [4:0]  poly_order;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] poly_value;
        logic signed [23:0] deriv_value;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic no_steps;
        logic last_step;
    } status_t;

    // B_k = k/(k+1) with COEF_FRAC fraction bits, rounded to nearest.
    // A_k = (2k+1)/(k+1) is exactly B_k + 1.0 at this precision.
    function automatic logic [15:0] coef_b(input logic [4:0] k);
        logic [15:0] b;
        unique case (k)
            5'd1:    b = 16'd32768;
            5'd2:    b = 16'd43691;
            5'd3:    b = 16'd49152;
            5'd4:    b = 16'd52429;
            5'd5:    b = 16'd54613;
            5'd6:    b = 16'd56174;
            5'd7:    b = 16'd57344;
            5'd8:    b = 16'd58254;
            5'd9:    b = 16'd58982;
            5'd10:   b = 16'd59578;
            5'd11:   b = 16'd60075;
            5'd12:   b = 16'd60495;
            5'd13:   b = 16'd60855;
            5'd14:   b = 16'd61167;
            5'd15:   b = 16'd61440;
            5'd16:   b = 16'd61681;
            5'd17:   b = 16'd61895;
            5'd18:   b = 16'd62087;
            5'd19:   b = 16'd62259;
            5'd20:   b = 16'd62415;
            5'd21:   b = 16'd62557;
            5'd22:   b = 16'd62687;
            5'd23:   b = 16'd62805;
            5'd24:   b = 16'd62915;
            5'd25:   b = 16'd63015;
            5'd26:   b = 16'd63109;
            5'd27:   b = 16'd63195;
            5'd28:   b = 16'd63276;
            5'd29:   b = 16'd63351;
            5'd30:   b = 16'd63422;
            default: b = 16'd0;
        endcase
        return b;
    endfunction

    // Derivative clamp for order i: i(i+1)/2 in value scale.
    function automatic logic [23:0] deriv_bound(input logic [4:0] i);
        logic [9:0] prod;
        logic [8:0] tri_num;
        prod    = 10'(i) * (10'(i) + 10'd1);
        tri_num = prod[9:1];
        return 24'(tri_num) << FRAC_BITS;
    endfunction

endpackage

/* rtl/lpd_controller.sv */
// Sequencing state machine for the Legendre recurrence.
// Depends on lpd_pkg.
module lpd_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lpd_pkg::status_t status,
    output lpd_pkg::cmd_t    cmd,
    output logic             busy
);

    lpd_pkg::state_t state_reg;
    lpd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lpd_pkg::ST_MUL;
                end
            end
            lpd_pkg::ST_MUL:
            begin
                // orders 0 and 1 need no recurrence step
                state_next = status.no_steps ? lpd_pkg::ST_OUT : lpd_pkg::ST_ACC;
            end
            lpd_pkg::ST_ACC:
            begin
                state_next = status.last_step ? lpd_pkg::ST_OUT : lpd_pkg::ST_MUL;
            end
            lpd_pkg::ST_OUT:
            begin
                state_next = lpd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            lpd_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            lpd_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            lpd_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            lpd_pkg::ST_OUT:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/lpd_datapath.sv */
// Recurrence datapath: operand registers, the two multiply phases of a
// step, rounding, clamping and the result register. Depends on lpd_pkg.
module lpd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  lpd_pkg::cmd_t      cmd,
    input  lpd_pkg::in_item_t  request,
    output lpd_pkg::status_t   status,
    output lpd_pkg::out_item_t result,
    output logic               done
);

    logic signed [15:0] x_reg;
    logic        [4:0]  n_reg;
    logic        [4:0]  i_reg;
    logic signed [15:0] p0_reg;
    logic signed [15:0] p1_reg;
    logic signed [23:0] d0_reg;
    logic signed [23:0] d1_reg;
    logic signed [15:0] xp_reg;
    logic signed [24:0] xds_reg;
    logic signed [32:0] bp_reg;
    logic signed [40:0] bd_reg;
    lpd_pkg::out_item_t result_reg;
    logic               done_reg;

    logic signed [15:0] x_in;
    logic        [4:0]  n_in;

    logic        [15:0] b_raw;
    logic signed [16:0] b_coef;
    logic signed [17:0] a_coef;

    logic signed [31:0] xp_prod;
    logic signed [31:0] xp_shift;
    logic signed [15:0] xp_next;
    logic signed [39:0] xd_prod;
    logic signed [39:0] xd_shift;
    logic signed [23:0] xd_val;
    logic signed [24:0] xds_next;
    logic signed [32:0] bp_next;
    logic signed [40:0] bd_next;

    logic signed [35:0] p_acc;
    logic signed [35:0] p_shift;
    logic signed [15:0] p_next;
    logic signed [44:0] d_acc;
    logic signed [44:0] d_shift;
    logic        [23:0] bound;
    logic signed [24:0] bound_s;
    logic signed [24:0] nbound_s;
    logic signed [23:0] d_next;

    // input clamps
    always_comb
    begin
        if (request.sample_x > 16'(lpd_pkg::ONE))
        begin
            x_in = 16'(lpd_pkg::ONE);
        end
        else if (request.sample_x < -16'(lpd_pkg::ONE))
        begin
            x_in = -16'(lpd_pkg::ONE);
        end
        else
        begin
            x_in = request.sample_x;
        end
        n_in = (request.poly_order > 5'(lpd_pkg::ORDER_CAP)) ?
               5'(lpd_pkg::ORDER_CAP) : request.poly_order;
    end

    assign b_raw  = lpd_pkg::coef_b(i_reg - 5'd1);
    assign b_coef = signed'({1'b0, b_raw});
    assign a_coef = signed'({2'b01, b_raw});

    // first phase: x products rounded, B products
    assign xp_prod  = x_reg * p1_reg;
    assign xp_shift = (xp_prod + 32'(lpd_pkg::HALF_X)) >>> lpd_pkg::FRAC_BITS;
    assign xp_next  = xp_shift[15:0];
    assign xd_prod  = x_reg * d1_reg;
    assign xd_shift = (xd_prod + 40'(lpd_pkg::HALF_X)) >>> lpd_pkg::FRAC_BITS;
    assign xd_val   = xd_shift[23:0];
    assign xds_next = 25'(p1_reg) + 25'(xd_val);
    assign bp_next  = b_coef * p0_reg;
    assign bd_next  = b_coef * d0_reg;

    // second phase: A products, difference, rounding and clamp
    assign p_acc   = a_coef * xp_reg - bp_reg + 36'(lpd_pkg::HALF_C);
    assign p_shift = p_acc >>> lpd_pkg::COEF_FRAC;
    assign d_acc   = a_coef * xds_reg - bd_reg + 45'(lpd_pkg::HALF_C);
    assign d_shift = d_acc >>> lpd_pkg::COEF_FRAC;

    assign bound    = lpd_pkg::deriv_bound(i_reg);
    assign bound_s  = signed'({1'b0, bound});
    assign nbound_s = -bound_s;

    always_comb
    begin
        if (p_shift > 36'(lpd_pkg::ONE))
        begin
            p_next = 16'(lpd_pkg::ONE);
        end
        else if (p_shift < -36'(lpd_pkg::ONE))
        begin
            p_next = -16'(lpd_pkg::ONE);
        end
        else
        begin
            p_next = p_shift[15:0];
        end

        if (d_shift > bound_s)
        begin
            d_next = bound_s[23:0];
        end
        else if (d_shift < nbound_s)
        begin
            d_next = nbound_s[23:0];
        end
        else
        begin
            d_next = d_shift[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= x_in;
            n_reg  <= n_in;
            i_reg  <= 5'd2;
            p0_reg <= 16'(lpd_pkg::ONE);
            p1_reg <= x_in;
            d0_reg <= '0;
            d1_reg <= 24'(lpd_pkg::ONE);
        end
        else if (cmd.acc)
        begin
            p0_reg <= p1_reg;
            p1_reg <= p_next;
            d0_reg <= d1_reg;
            d1_reg <= d_next;
            i_reg  <= i_reg + 5'd1;
        end

        if (cmd.mul)
        begin
            xp_reg  <= xp_next;
            xds_reg <= xds_next;
            bp_reg  <= bp_next;
            bd_reg  <= bd_next;
        end

        if (cmd.finish)
        begin
            if (n_reg == 5'd0)
            begin
                result_reg.poly_value  <= 16'(lpd_pkg::ONE);
                result_reg.deriv_value <= '0;
            end
            else
            begin
                result_reg.poly_value  <= p1_reg;
                result_reg.deriv_value <= d1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign status.no_steps  = (n_reg < 5'd2);
    assign status.last_step = (i_reg == n_reg);
    assign result           = result_reg;
    assign done             = done_reg;

endmodule

/* rtl/legendre_poly_and_derivative_unit.sv */
// Top level of the Legendre polynomial and derivative unit.
// Depends on lpd_pkg, lpd_controller and lpd_datapath.
//
//  channel   ports                    handshake
//  --------  -----------------------  ---------------------------------
//  request   request (in_item_t)      taken when start && !busy
//  result    result  (out_item_t)     valid for one cycle while done
//
// Each recurrence step forms the x and B products in ST_MUL, then the A
// products, rounding and clamp in ST_ACC. Busy spans each step's ST_MUL
// and ST_ACC, then ST_OUT (orders 0 and 1: ST_MUL, ST_OUT); done follows
// the last busy cycle. A new transaction may start in the cycle that done
// is shown. Reset clears the sequencer and done strobe; no back-pressure.
module legendre_poly_and_derivative_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lpd_pkg::in_item_t  request,
    output logic               busy,
    output lpd_pkg::out_item_t result,
    output logic               done
);

    lpd_pkg::cmd_t    cmd;
    lpd_pkg::status_t status;

    lpd_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lpd_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .status  (status),
        .result  (result),
        .done    (done)
    );

endmodule

/* rtl/lpd_checker.sv */
// Port-level checks for the Legendre unit, bound to the top level.
// Depends on lpd_pkg and legendre_poly_and_derivative_unit.
module lpd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input lpd_pkg::in_item_t  request,
    input logic               busy,
    input lpd_pkg::out_item_t result,
    input logic               done
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("transaction finished without a result");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.poly_value <= 16'(lpd_pkg::ONE)) &&
                 (result.poly_value >= -16'(lpd_pkg::ONE)))
        else $error("polynomial value outside plus or minus one");

endmodule

bind legendre_poly_and_derivative_unit lpd_checker u_chk (.*);

/* sim/tb_legendre_poly_and_derivative_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for legendre_poly_and_derivative_unit: directed and random
// samples/orders, results checked against a fixed-point recurrence predictor.
// Depends on lpd_pkg and the unit RTL.
module tb_legendre_poly_and_derivative_unit;

    localparam longint IDLE_FREE_LO = 500;
    localparam longint IDLE_FREE_HI = 800;
    localparam int     TAIL_CYCLES  = 70;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    lpd_pkg::in_item_t  request = '0;
    logic               busy;
    lpd_pkg::out_item_t result;
    logic               done;

    lpd_pkg::in_item_t  pending_items[$];
    lpd_pkg::out_item_t expected_results[$];
    lpd_pkg::out_item_t want_item;

    int        gap_cycles;
    int        sent_count;
    int        result_count;
    int        error_count;
    int        order0_count;
    int        order1_count;
    int        clamped_x_count;
    logic      took;

    legendre_poly_and_derivative_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .result  (result),
        .done    (done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Round to nearest, half toward +infinity (>>> on longint is a floor).
    function automatic longint round_down_by(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // P_n(x) and P_n'(x) by the three-term recurrence at the unit's precision.
    function automatic lpd_pkg::out_item_t legendre_eval(input lpd_pkg::in_item_t item);
        longint             one;
        longint             x;
        longint             n;
        longint             p_prev;
        longint             p_cur;
        longint             p_next;
        longint             d_prev;
        longint             d_cur;
        longint             d_next;
        longint             k;
        longint             coef_a;
        longint             coef_b;
        longint             bound;
        longint             xp;
        longint             xd;
        lpd_pkg::out_item_t r;
        one = longint'(1) << lpd_pkg::FRAC_BITS;
        x   = clip(longint'($signed(item.sample_x)), -one, one);
        n   = longint'(item.poly_order);
        if (n > lpd_pkg::ORDER_CAP)
            n = lpd_pkg::ORDER_CAP;
        p_prev = one;
        p_cur  = x;
        d_prev = 0;
        d_cur  = one;
        for (longint i = 2; i <= n; i++)
        begin
            k      = i - 1;
            coef_a = (((2 * k + 1) << lpd_pkg::COEF_FRAC) + (k + 1) / 2) / (k + 1);
            coef_b = ((k << lpd_pkg::COEF_FRAC) + (k + 1) / 2) / (k + 1);
            bound  = ((i * (i + 1)) / 2) * one;
            xp     = round_down_by(x * p_cur, lpd_pkg::FRAC_BITS);
            xd     = round_down_by(x * d_cur, lpd_pkg::FRAC_BITS);
            p_next = round_down_by(coef_a * xp - coef_b * p_prev, lpd_pkg::COEF_FRAC);
            d_next = round_down_by(coef_a * (p_cur + xd) - coef_b * d_prev,
                                   lpd_pkg::COEF_FRAC);
            p_prev = p_cur;
            p_cur  = clip(p_next, -one, one);
            d_prev = d_cur;
            d_cur  = clip(d_next, -bound, bound);
        end
        if (n == 0)
        begin
            p_cur = one;
            d_cur = 0;
        end
        r.poly_value  = 16'(p_cur);
        r.deriv_value = 24'(d_cur);
        return r;
    endfunction

    task automatic add_item(input int x, input int order);
        lpd_pkg::in_item_t item;
        item.sample_x   = 16'(x);
        item.poly_order = 5'(order);
        pending_items.insert(pending_items.size(), item);
    endtask

    // Driver: holds each transaction until taken, then may back off for a while
    // so that the next start lands on a different phase of the recurrence.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            request    <= '0;
            gap_cycles = 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                expected_results.insert(expected_results.size(), legendre_eval(request));
                sent_count++;
                if (request.poly_order == 0)
                    order0_count++;
                if (request.poly_order == 1)
                    order1_count++;
                if ($signed(request.sample_x) > lpd_pkg::ONE ||
                    $signed(request.sample_x) < -lpd_pkg::ONE)
                    clamped_x_count++;
                if ((sent_count < IDLE_FREE_LO || sent_count >= IDLE_FREE_HI)
                    && $urandom_range(99) < 40)
                    gap_cycles = $urandom_range(70, 1);
            end
            if (took || !start)
            begin
                if (gap_cycles > 0)
                begin
                    gap_cycles--;
                    start <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    start   <= 1'b1;
                    request <= pending_items.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: done is a one-cycle strobe, taken at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, poly %0d deriv %0d", $time,
                         result.poly_value, result.deriv_value);
                error_count++;
            end
            else
            begin
                want_item = expected_results.pop_front();
                result_count++;
                if (result.poly_value !== want_item.poly_value)
                begin
                    $display("%0t: poly_value mismatch, expected %0d actual %0d", $time,
                             want_item.poly_value, result.poly_value);
                    error_count++;
                end
                if (result.deriv_value !== want_item.deriv_value)
                begin
                    $display("%0t: deriv_value mismatch, expected %0d actual %0d", $time,
                             want_item.deriv_value, result.deriv_value);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int x;
        // endpoints, zero, tiny and out-of-range samples; orders 0, 1, 2 and top
        add_item(16384, 0);
        add_item(16384, 1);
        add_item(16384, 2);
        add_item(16384, 31);
        add_item(-16384, 31);
        add_item(-16384, 30);
        add_item(0, 0);
        add_item(0, 1);
        add_item(0, 2);
        add_item(0, 31);
        add_item(1, 31);
        add_item(-1, 30);
        add_item(8192, 5);
        add_item(-8192, 5);
        add_item(32767, 7);
        add_item(-32768, 7);
        add_item(16385, 3);
        add_item(-16385, 4);
        add_item(11585, 31);
        add_item(-5000, 17);
        add_item(16383, 31);
        add_item(-16383, 16);
        add_item(4096, 9);
        add_item(-12000, 1);
        for (int i = 0; i < 1400; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                x = $signed(16'($urandom));
            else if (r < 14)
            begin
                case ($urandom_range(4))
                    0:       x = 16384;
                    1:       x = -16384;
                    2:       x = 1;
                    3:       x = -1;
                    default: x = 0;
                endcase
            end
            else
                x = int'($urandom_range(32768)) - 16384;
            add_item(x, $urandom_range(31));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d transactions (%0d of order 0, %0d of order 1,",
                 sent_count, order0_count, order1_count);
        $display("%0d samples clamped), %0d results checked, %0d mismatches.",
                 clamped_x_count, result_count, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
